/* hdl/acsb_pkg.sv */
package acsb_pkg;

   localparam int unsigned CORDIC_STEPS_DEF = 20;
   localparam int unsigned SAMPLE_BITS_DEF  = 24;

   localparam int unsigned ANGLE_BITS    = 32;
   localparam int unsigned GAIN_BITS     = 16;
   localparam int unsigned MIX_BITS      = 16;
   localparam int unsigned WEIGHT_BITS   = MIX_BITS + 1;
   localparam int unsigned LEVEL_BITS    = 15;
   localparam int unsigned CSR_ADDR_BITS = 4;
   localparam int unsigned CSR_DATA_BITS = 32;

   localparam logic [GAIN_BITS-1:0]          GAIN_RESET   = 16'd4096;
   localparam logic [MIX_BITS-1:0]           MIX_RESET    = 16'd20480;
   localparam logic signed [WEIGHT_BITS-1:0] UNITY_WEIGHT = 17'sd4096;
   localparam logic [LEVEL_BITS-1:0]         LEVEL_RESET  = 15'd16384;

   typedef enum logic [1:0] {
      REG_DRIVE_GAIN   = 2'd0,
      REG_MIX_AMOUNT   = 2'd1,
      REG_OUTPUT_LEVEL = 2'd2,
      REG_BYPASS       = 2'd3
   } acsb_reg_type;

   typedef struct packed {
      logic [GAIN_BITS-1:0]          drive_gain;
      logic [MIX_BITS-1:0]           mix_amount;
      logic signed [WEIGHT_BITS-1:0] dry_weight;
      logic [LEVEL_BITS-1:0]         output_level;
      logic                          bypass;
   } acsb_cfg_type;

   // atan(2^-i), 2^30 = pi/2
   function automatic logic signed [ANGLE_BITS-1:0] atan_step(input int unsigned i);
      logic signed [ANGLE_BITS-1:0] a;
      case (i)
         0:       a = 32'sh20000000;
         1:       a = 32'sh12E4051E;
         2:       a = 32'sh09FB385B;
         3:       a = 32'sh051111D4;
         4:       a = 32'sh028B0D43;
         5:       a = 32'sh0145D7E1;
         6:       a = 32'sh00A2F61E;
         7:       a = 32'sh00517C55;
         8:       a = 32'sh0028BE53;
         9:       a = 32'sh00145F2F;
         10:      a = 32'sh000A2F98;
         11:      a = 32'sh000517CC;
         12:      a = 32'sh00028BE6;
         13:      a = 32'sh000145F3;
         14:      a = 32'sh0000A2FA;
         15:      a = 32'sh0000517D;
         16:      a = 32'sh000028BE;
         17:      a = 32'sh0000145F;
         18:      a = 32'sh00000A30;
         19:      a = 32'sh00000518;
         20:      a = 32'sh0000028C;
         21:      a = 32'sh00000146;
         22:      a = 32'sh000000A3;
         23:      a = 32'sh00000051;
         24:      a = 32'sh00000029;
         25:      a = 32'sh00000014;
         26:      a = 32'sh0000000A;
         27:      a = 32'sh00000005;
         28:      a = 32'sh00000003;
         29:      a = 32'sh00000001;
         30:      a = 32'sh00000001;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

/* hdl/acsb_ifc.sv */
interface acsb_req_if #(
   parameter int unsigned SAMPLE_BITS = acsb_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface acsb_rsp_if #(
   parameter int unsigned SAMPLE_BITS = acsb_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          saturated;

   modport source (output valid, output sample_out, output saturated, input ready);
   modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

/* hdl/acsb_csr.sv */
module acsb_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [acsb_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [acsb_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [acsb_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output acsb_pkg::acsb_cfg_type               cfg
);
   import acsb_pkg::*;

   acsb_reg_type                  reg_sel;
   logic                          wr_en;
   logic [GAIN_BITS-1:0]          gain_ff, gain_in;
   logic [MIX_BITS-1:0]           mix_ff, mix_in;
   logic signed [WEIGHT_BITS-1:0] dry_ff, dry_in;
   logic [LEVEL_BITS-1:0]         level_ff, level_in;
   logic                          bypass_ff, bypass_in;

   assign reg_sel    = acsb_reg_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      gain_in   = gain_ff;
      mix_in    = mix_ff;
      dry_in    = dry_ff;
      level_in  = level_ff;
      bypass_in = bypass_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_DRIVE_GAIN: begin
               gain_in = csr_pwdata[GAIN_BITS-1:0];
            end
            REG_MIX_AMOUNT: begin
               mix_in = csr_pwdata[MIX_BITS-1:0];
               // keep the dry weight (1 - blend) ready for the datapath
               dry_in = UNITY_WEIGHT - $signed({1'b0, csr_pwdata[MIX_BITS-1:0]});
            end
            REG_OUTPUT_LEVEL: begin
               level_in = csr_pwdata[LEVEL_BITS-1:0];
            end
            REG_BYPASS: begin
               bypass_in = csr_pwdata[0];
            end
            default: begin
               gain_in = gain_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= GAIN_RESET;
         mix_ff    <= MIX_RESET;
         dry_ff    <= UNITY_WEIGHT - $signed({1'b0, MIX_RESET});
         level_ff  <= LEVEL_RESET;
         bypass_ff <= 1'b0;
      end else begin
         gain_ff   <= gain_in;
         mix_ff    <= mix_in;
         dry_ff    <= dry_in;
         level_ff  <= level_in;
         bypass_ff <= bypass_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_DRIVE_GAIN:   csr_prdata = CSR_DATA_BITS'(gain_ff);
         REG_MIX_AMOUNT:   csr_prdata = CSR_DATA_BITS'(mix_ff);
         REG_OUTPUT_LEVEL: csr_prdata = CSR_DATA_BITS'(level_ff);
         REG_BYPASS:       csr_prdata = CSR_DATA_BITS'(bypass_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg.drive_gain   = gain_ff;
   assign cfg.mix_amount   = mix_ff;
   assign cfg.dry_weight   = dry_ff;
   assign cfg.output_level = level_ff;
   assign cfg.bypass       = bypass_ff;

endmodule

/* hdl/acsb_cordic.sv */
module acsb_cordic #(
   parameter int unsigned CORDIC_STEPS = acsb_pkg::CORDIC_STEPS_DEF,
   parameter int unsigned SAMPLE_BITS  = acsb_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    en,
   input  logic                                    in_valid,
   input  logic signed [SAMPLE_BITS-1:0]           in_x,
   input  logic [acsb_pkg::GAIN_BITS-1:0]          gain,
   output logic                                    out_valid,
   output logic signed [SAMPLE_BITS-1:0]           out_x,
   output logic signed [acsb_pkg::ANGLE_BITS-1:0]  out_z
);
   import acsb_pkg::*;

   localparam int unsigned NS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
   localparam int unsigned CW = SAMPLE_BITS + 18;
   localparam logic signed [CW-1:0] X_START =
      {{(6){1'b0}}, 1'b1, {(SAMPLE_BITS + 11){1'b0}}};

   logic                          va_ff, va_in;
   logic [SAMPLE_BITS-1:0]        ax_ff, ax_in;
   logic signed [SAMPLE_BITS-1:0] xa_ff;

   logic signed [CW-1:0]          cx_ff [0:NS];
   logic signed [CW-1:0]          cx_in [0:NS];
   logic signed [CW-1:0]          cy_ff [0:NS];
   logic signed [CW-1:0]          cy_in [0:NS];
   logic signed [ANGLE_BITS-1:0]  cz_ff [0:NS];
   logic signed [ANGLE_BITS-1:0]  cz_in [0:NS];
   logic signed [SAMPLE_BITS-1:0] cs_ff [0:NS];
   logic signed [SAMPLE_BITS-1:0] cs_in [0:NS];
   logic [NS:0]                   cv_ff, cv_in;

   // magnitude of the sample; the most negative value maps to 2^(N-1)
   assign va_in = in_valid;
   assign ax_in = in_x[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_x) : SAMPLE_BITS'(in_x);

   // seed: X = 1.0, Y = gain * |x|
   assign cx_in[0] = X_START;
   assign cy_in[0] = $signed(CW'(ax_ff * gain));
   assign cz_in[0] = '0;
   assign cs_in[0] = xa_ff;
   assign cv_in    = {cv_ff[NS-1:0], va_ff};

   for (genvar k = 0; k < NS; k++) begin : g_step
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      assign xs = cx_ff[k] >>> k;
      assign ys = cy_ff[k] >>> k;
      always_comb begin
         if (!cy_ff[k][CW-1]) begin
            cx_in[k+1] = cx_ff[k] + ys;
            cy_in[k+1] = cy_ff[k] - xs;
            cz_in[k+1] = cz_ff[k] + atan_step(k);
         end else begin
            cx_in[k+1] = cx_ff[k] - ys;
            cy_in[k+1] = cy_ff[k] + xs;
            cz_in[k+1] = cz_ff[k] - atan_step(k);
         end
      end
      assign cs_in[k+1] = cs_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         cv_ff <= '0;
      end else if (en) begin
         va_ff <= va_in;
         cv_ff <= cv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff <= ax_in;
         xa_ff <= in_x;
         for (int i = 0; i <= NS; i++) begin
            cx_ff[i] <= cx_in[i];
            cy_ff[i] <= cy_in[i];
            cz_ff[i] <= cz_in[i];
            cs_ff[i] <= cs_in[i];
         end
      end
   end

   assign out_valid = cv_ff[NS];
   assign out_x     = cs_ff[NS];
   assign out_z     = cz_ff[NS];

endmodule

/* hdl/atan_soft_clip_blend_unit.sv */
// Channel  Role        Beat payload                 Handshake
// req_ch   input       sample_in (signed)           valid / ready
// rsp_ch   output      sample_out (signed), flag    valid / ready
// csr_*    config      drive/mix/level/bypass       APB, pready tied high
//
// One beat per cycle sustained while rsp_ch.ready holds; the pipeline is built
// from one CORDIC iteration per pipeline stage plus seven arithmetic stages.
// Synchronous reset empties the pipeline and loads the register defaults.
// The output register is backed by one skid entry; req_ch.ready drops only
// while that entry is occupied, and the whole pipeline holds with it.
module atan_soft_clip_blend_unit #(
   parameter int unsigned CORDIC_STEPS = acsb_pkg::CORDIC_STEPS_DEF,
   parameter int unsigned SAMPLE_BITS  = acsb_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   acsb_req_if.sink                           req_ch,
   acsb_rsp_if.source                         rsp_ch,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [acsb_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [acsb_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [acsb_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);
   import acsb_pkg::*;

   localparam int unsigned PZW = ANGLE_BITS + WEIGHT_BITS;
   localparam int unsigned IW  = PZW + 1;
   localparam int unsigned LOW = 25;
   localparam int unsigned PLW = LOW + LEVEL_BITS;
   localparam int unsigned PHW = (IW - LOW) + LEVEL_BITS + 1;
   localparam int unsigned PW  = IW + LEVEL_BITS + 1;
   localparam int unsigned SH  = 57 - SAMPLE_BITS;
   localparam logic signed [PW-1:0] ROUND = {{(PW-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}};
   localparam logic signed [PW-1:0] MAXV  =
      {{(PW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [PW-1:0] MINV  = ~MAXV;
   localparam logic [SAMPLE_BITS-1:0] RAIL_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] RAIL_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   acsb_cfg_type                  cfg;
   logic                          en;
   logic                          cv;
   logic signed [SAMPLE_BITS-1:0] cx;
   logic signed [ANGLE_BITS-1:0]  cz;

   logic signed [ANGLE_BITS-1:0]  xq;
   logic                          mv_ff;
   logic signed [SAMPLE_BITS-1:0] mx_ff;
   logic signed [PZW-1:0]         pz_ff, pz_in;
   logic signed [PZW-1:0]         px_ff, px_in;

   logic                          sv_ff;
   logic signed [SAMPLE_BITS-1:0] sx_ff;
   logic signed [IW-1:0]          inner_ff, inner_in;

   logic                          pv_ff;
   logic signed [SAMPLE_BITS-1:0] px2_ff;
   logic [PLW-1:0]                plo_ff, plo_in;
   logic signed [PHW-1:0]         phi_ff, phi_in;

   logic                          rv_ff;
   logic signed [SAMPLE_BITS-1:0] rx_ff;
   logic signed [PW-1:0]          sum_ff, sum_in;

   logic signed [PW-1:0]          y;
   logic                          over_hi;
   logic                          over_lo;
   logic [SAMPLE_BITS-1:0]        res_sample;
   logic                          res_sat;

   logic                          out_v_ff, out_v_in;
   logic [SAMPLE_BITS-1:0]        out_s_ff, out_s_in;
   logic                          out_f_ff, out_f_in;
   logic                          skid_v_ff, skid_v_in;
   logic [SAMPLE_BITS-1:0]        skid_s_ff, skid_s_in;
   logic                          skid_f_ff, skid_f_in;
   logic                          load_pipe;
   logic                          load_skid;

   acsb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign en           = !skid_v_ff;
   assign req_ch.ready = en;

   acsb_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid),
      .in_x      (SAMPLE_BITS'(req_ch.sample_in)),
      .gain      (cfg.drive_gain),
      .out_valid (cv),
      .out_x     (cx),
      .out_z     (cz)
   );

   // bring the sample to Q30
   if (SAMPLE_BITS <= 31) begin : g_xq_up
      assign xq = ANGLE_BITS'(cx) <<< (31 - SAMPLE_BITS);
   end else begin : g_xq_down
      assign xq = ANGLE_BITS'(cx >>> (SAMPLE_BITS - 31));
   end

   // wet and dry products; the sign of x is applied in the sum
   assign pz_in = cz * $signed({1'b0, cfg.mix_amount});
   assign px_in = xq * $signed(cfg.dry_weight);

   assign inner_in = mx_ff[SAMPLE_BITS-1] ? IW'(px_ff) - IW'(pz_ff)
                                          : IW'(px_ff) + IW'(pz_ff);

   // split the level multiply into two partial products
   assign plo_in = inner_ff[LOW-1:0] * cfg.output_level;
   assign phi_in = $signed(inner_ff[IW-1:LOW]) * $signed({1'b0, cfg.output_level});

   assign sum_in = (PW'(phi_ff) <<< LOW) + $signed(PW'(plo_ff)) + ROUND;

   assign y       = sum_ff >>> SH;
   assign over_hi = y > MAXV;
   assign over_lo = y < MINV;

   always_comb begin
      if (cfg.bypass) begin
         res_sample = rx_ff;
         res_sat    = 1'b0;
      end else if (over_hi) begin
         res_sample = RAIL_HI;
         res_sat    = 1'b1;
      end else if (over_lo) begin
         res_sample = RAIL_LO;
         res_sat    = 1'b1;
      end else begin
         res_sample = y[SAMPLE_BITS-1:0];
         res_sat    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 1'b0;
         sv_ff <= 1'b0;
         pv_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else if (en) begin
         mv_ff <= cv;
         sv_ff <= mv_ff;
         pv_ff <= sv_ff;
         rv_ff <= pv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff    <= cx;
         pz_ff    <= pz_in;
         px_ff    <= px_in;
         sx_ff    <= mx_ff;
         inner_ff <= inner_in;
         px2_ff   <= sx_ff;
         plo_ff   <= plo_in;
         phi_ff   <= phi_in;
         rx_ff    <= px2_ff;
         sum_ff   <= sum_in;
      end
   end

   // output register with one skid entry behind it
   always_comb begin
      out_v_in  = out_v_ff;
      skid_v_in = skid_v_ff;
      load_pipe = 1'b0;
      load_skid = 1'b0;
      if (en) begin
         if (!out_v_ff || rsp_ch.ready) begin
            out_v_in  = rv_ff;
            load_pipe = 1'b1;
         end else if (rv_ff) begin
            skid_v_in = 1'b1;
         end
      end else if (rsp_ch.ready) begin
         out_v_in  = 1'b1;
         skid_v_in = 1'b0;
         load_skid = 1'b1;
      end
   end

   always_comb begin
      out_s_in  = out_s_ff;
      out_f_in  = out_f_ff;
      skid_s_in = skid_s_ff;
      skid_f_in = skid_f_ff;
      if (load_pipe) begin
         out_s_in = res_sample;
         out_f_in = res_sat;
      end else if (load_skid) begin
         out_s_in = skid_s_ff;
         out_f_in = skid_f_ff;
      end
      if (en && !load_pipe) begin
         skid_s_in = res_sample;
         skid_f_in = res_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_s_ff  <= out_s_in;
      out_f_ff  <= out_f_in;
      skid_s_ff <= skid_s_in;
      skid_f_ff <= skid_f_in;
   end

   assign rsp_ch.valid      = out_v_ff;
   assign rsp_ch.sample_out = out_s_ff;
   assign rsp_ch.saturated  = out_f_ff;

`ifndef SYNTHESIS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry held while output register empty");

   a_skid_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_ch.ready && rv_ff))
      else $error("skid entry filled without a stalled output");

   a_sat_at_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.saturated) |->
         (rsp_ch.sample_out == RAIL_HI || rsp_ch.sample_out == RAIL_LO))
      else $error("saturation flag without a rail value");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> (!out_v_ff && !skid_v_ff && !rv_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import acsb_pkg::*;

   localparam int SW          = SAMPLE_BITS_DEF;
   localparam int STEPS       = (CORDIC_STEPS_DEF > 32) ? 32 : CORDIC_STEPS_DEF;
   localparam int PIPE_DEPTH  = CORDIC_STEPS_DEF + 7;
   localparam int QUIET_LIMIT = 5000;
   localparam int PHASES      = 12;
   localparam int PHASE_BEATS = 140;
   localparam int PRESSURE_PHASE = 8;

   // atan(2^-i) with 2^30 = pi/2, entry 0 in the top word
   localparam logic [32*32-1:0] ANGLE_TABLE = {
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic [GAIN_BITS-1:0]  drive_gain;
      logic [MIX_BITS-1:0]   mix_amount;
      logic [LEVEL_BITS-1:0] output_level;
      logic                  bypass;
   } knob_set_type;

   typedef struct packed {
      logic signed [SW-1:0] audio;
      logic                 clipped;
   } clip_beat_type;

   typedef struct packed {
      knob_set_type         knobs;
      logic signed [SW-1:0] stim;
      logic                 typed;
      clip_beat_type        want;
   } drill_row_type;

   logic clock;
   logic reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   acsb_req_if #(.SAMPLE_BITS(SW)) req_if ();
   acsb_rsp_if #(.SAMPLE_BITS(SW)) rsp_if ();

   atan_soft_clip_blend_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   knob_set_type  live_knobs;
   clip_beat_type pending_clips[$];
   int            fail_count;
   int            send_idle_pct;
   int            recv_idle_pct;
   int            hold_request;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic clip_beat_type clip_blend_predict(input logic signed [SW-1:0] x);
      clip_beat_type r;
      longint sx, ax, cx, cy, xs, ys, z, xq, inner, prod, y, maxv;
      int i;
      r.clipped = 1'b0;
      r.audio   = x;
      if (live_knobs.bypass)
         return r;
      sx = longint'(x);
      ax = (sx < 0) ? -sx : sx;
      cx = longint'(1) << (SW + 11);
      cy = longint'(live_knobs.drive_gain) * ax;
      z  = 0;
      for (i = 0; i < STEPS; i++) begin
         xs = cx >>> i;
         ys = cy >>> i;
         if (cy >= 0) begin
            cx = cx + ys;
            cy = cy - xs;
            z  = z + longint'(ANGLE_TABLE[(31 - i) * 32 +: 32]);
         end else begin
            cx = cx - ys;
            cy = cy + xs;
            z  = z - longint'(ANGLE_TABLE[(31 - i) * 32 +: 32]);
         end
      end
      if (sx < 0)
         z = -z;
      xq    = sx << (31 - SW);
      inner = z * longint'(live_knobs.mix_amount)
            + xq * (longint'(4096) - longint'(live_knobs.mix_amount));
      prod  = inner * longint'(live_knobs.output_level);
      y     = (prod + (longint'(1) << (56 - SW))) >>> (57 - SW);
      maxv  = (longint'(1) << (SW - 1)) - 1;
      if (y > maxv) begin
         y = maxv;
         r.clipped = 1'b1;
      end else if (y < -maxv - 1) begin
         y = -maxv - 1;
         r.clipped = 1'b1;
      end
      r.audio = y[SW-1:0];
      return r;
   endfunction

   function automatic knob_set_type mk_knobs(input logic [15:0] g, input logic [15:0] m,
                                             input logic [14:0] l, input logic b);
      knob_set_type k;
      k.drive_gain   = g;
      k.mix_amount   = m;
      k.output_level = l;
      k.bypass       = b;
      return k;
   endfunction

   function automatic drill_row_type mk_row(input knob_set_type k,
                                            input logic signed [SW-1:0] x,
                                            input logic typed, input logic signed [SW-1:0] y,
                                            input logic sat);
      drill_row_type row;
      row.knobs        = k;
      row.stim         = x;
      row.typed        = typed;
      row.want.audio   = y;
      row.want.clipped = sat;
      return row;
   endfunction

   function automatic knob_set_type pick_knobs(input int p);
      knob_set_type k;
      k = mk_knobs(16'($urandom_range(2048, 40960)), 16'($urandom_range(0, 40960)),
                   15'($urandom_range(4115, 32690)), 1'b0);
      case (p)
         0: k = mk_knobs(16'd2048, 16'd0, 15'd4115, 1'b0);
         1: k = mk_knobs(16'd40960, 16'd40960, 15'd32690, 1'b0);
         2: k = mk_knobs(16'hFFFF, 16'hFFFF, 15'h7FFF, 1'b0);
         3: k = mk_knobs(16'd0, 16'd4096, 15'd0, 1'b0);
         5, 10: k.bypass = 1'b1;
         default: ;
      endcase
      return k;
   endfunction

   function automatic logic signed [SW-1:0] draw_sample();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 9))
         0: return SW'($urandom_range(0, 511)) - SW'(256);
         1: return r[0] ? (24'h7FFFFF - SW'($urandom_range(0, 15)))
                        : (24'h800000 + SW'($urandom_range(0, 15)));
         default: return r[SW-1:0];
      endcase
   endfunction

   task automatic write_csr(input acsb_reg_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_DRIVE_GAIN:   live_knobs.drive_gain   = value[GAIN_BITS-1:0];
         REG_MIX_AMOUNT:   live_knobs.mix_amount   = value[MIX_BITS-1:0];
         REG_OUTPUT_LEVEL: live_knobs.output_level = value[LEVEL_BITS-1:0];
         REG_BYPASS:       live_knobs.bypass       = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // junk in the unused upper bits must be dropped by the block
   task automatic apply_knobs(input knob_set_type k);
      write_csr(REG_DRIVE_GAIN,   {16'($urandom()), k.drive_gain});
      write_csr(REG_MIX_AMOUNT,   {16'($urandom()), k.mix_amount});
      write_csr(REG_OUTPUT_LEVEL, {17'($urandom()), k.output_level});
      write_csr(REG_BYPASS,       {31'($urandom()), k.bypass});
   endtask

   task automatic offer_sample(input logic signed [SW-1:0] x, input logic typed,
                               input clip_beat_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.sample_in <= x;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (typed)
         pending_clips.push_back(want);
      else
         pending_clips.push_back(clip_blend_predict(x));
   endtask

   task automatic settle_block();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_clips.size() != 0) @(posedge clock);
   endtask

   task automatic check_clip(input clip_beat_type got);
      clip_beat_type exp_beat;
      if (pending_clips.size() == 0) begin
         $display("%0t: unexpected beat sample_out=%0d saturated=%0b",
                  $time, $signed(got.audio), got.clipped);
         fail_count++;
         return;
      end
      exp_beat = pending_clips.pop_front();
      if (got.audio !== exp_beat.audio) begin
         $display("%0t: sample_out expected %0d, got %0d",
                  $time, $signed(exp_beat.audio), $signed(got.audio));
         fail_count++;
      end
      if (got.clipped !== exp_beat.clipped) begin
         $display("%0t: saturated expected %0b, got %0b",
                  $time, exp_beat.clipped, got.clipped);
         fail_count++;
      end
   endtask

   // result side: check, then pick next ready; long hold on request
   initial begin
      int hold_left;
      clip_beat_type got;
      hold_left = 0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            got.audio   = rsp_if.sample_out;
            got.clipped = rsp_if.saturated;
            check_clip(got);
         end
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      drill_row_type drill[$];
      knob_set_type  k_def, k_byp, k_flat, k_hot, k_clamp;
      int n, p;

      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.sample_in = '0;
      rsp_if.ready     = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      fail_count       = 0;
      hold_request     = 0;
      send_idle_pct    = 37;
      recv_idle_pct    = 80;
      live_knobs       = mk_knobs(GAIN_RESET, MIX_RESET, LEVEL_RESET, 1'b0);

      k_def   = live_knobs;
      k_byp   = mk_knobs(GAIN_RESET, MIX_RESET, LEVEL_RESET, 1'b1);
      k_flat  = mk_knobs(16'd4096, 16'd0, 15'd16384, 1'b0);
      k_hot   = mk_knobs(16'hFFFF, 16'hFFFF, 15'h7FFF, 1'b0);
      k_clamp = mk_knobs(16'd2048, 16'd0, 15'h7FFF, 1'b0);

      // reset values; zero input leaves only a CORDIC residue
      drill.push_back(mk_row(k_def, 24'h000000, 1'b0, 24'h0, 1'b0));
      drill.push_back(mk_row(k_def, 24'h7FFFFF, 1'b0, 24'h0, 1'b0));
      drill.push_back(mk_row(k_def, 24'h800000, 1'b0, 24'h0, 1'b0));
      drill.push_back(mk_row(k_def, 24'h000001, 1'b0, 24'h0, 1'b0));
      drill.push_back(mk_row(k_def, 24'hFFFFFF, 1'b0, 24'h0, 1'b0));
      drill.push_back(mk_row(k_def, 24'h400000, 1'b0, 24'h0, 1'b0));
      // pass-through ignores every knob
      drill.push_back(mk_row(k_byp, 24'h7FFFFF, 1'b1, 24'h7FFFFF, 1'b0));
      drill.push_back(mk_row(k_byp, 24'h800000, 1'b1, 24'h800000, 1'b0));
      drill.push_back(mk_row(k_byp, 24'h000000, 1'b1, 24'h000000, 1'b0));
      drill.push_back(mk_row(k_byp, 24'h555555, 1'b1, 24'h555555, 1'b0));
      drill.push_back(mk_row(k_byp, 24'hAAAAAA, 1'b1, 24'hAAAAAA, 1'b0));
      // all dry at unity level reproduces the input
      drill.push_back(mk_row(k_flat, 24'h7FFFFF, 1'b1, 24'h7FFFFF, 1'b0));
      drill.push_back(mk_row(k_flat, 24'h800000, 1'b1, 24'h800000, 1'b0));
      drill.push_back(mk_row(k_flat, 24'h123456, 1'b1, 24'h123456, 1'b0));
      drill.push_back(mk_row(k_flat, 24'hFFFFFF, 1'b1, 24'hFFFFFF, 1'b0));
      // full-scale knobs, blend far above one
      drill.push_back(mk_row(k_hot, 24'h7FFFFF, 1'b0, 24'h0, 1'b0));
      drill.push_back(mk_row(k_hot, 24'h800000, 1'b0, 24'h0, 1'b0));
      drill.push_back(mk_row(k_hot, 24'h000001, 1'b0, 24'h0, 1'b0));
      drill.push_back(mk_row(k_hot, 24'hFFFFFF, 1'b0, 24'h0, 1'b0));
      drill.push_back(mk_row(k_hot, 24'h000000, 1'b0, 24'h0, 1'b0));
      // dry path at level near two clamps both rails
      drill.push_back(mk_row(k_clamp, 24'h7FFFFF, 1'b1, 24'h7FFFFF, 1'b1));
      drill.push_back(mk_row(k_clamp, 24'h800000, 1'b1, 24'h800000, 1'b1));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < drill.size(); n++) begin
         if (drill[n].knobs != live_knobs) begin
            settle_block();
            apply_knobs(drill[n].knobs);
         end
         offer_sample(drill[n].stim, drill[n].typed, drill[n].want);
      end

      for (p = 0; p < PHASES; p++) begin
         settle_block();
         apply_knobs(pick_knobs(p));
         if (p < 4) begin
            send_idle_pct = 37;
            recv_idle_pct = 80;
         end else if (p < 8) begin
            send_idle_pct = 80;
            recv_idle_pct = 37;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // starve the output so the pipeline backs up into the input
         if (p == PRESSURE_PHASE)
            hold_request = 300;
         for (n = 0; n < PHASE_BEATS; n++)
            offer_sample(draw_sample(), 1'b0, '0);
      end

      settle_block();
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* filelist.f */
hdl/acsb_pkg.sv
hdl/acsb_ifc.sv
hdl/acsb_csr.sv
hdl/acsb_cordic.sv
hdl/atan_soft_clip_blend_unit.sv
tb/tb_top.sv
